/* hw/rtl/bpsb_pkg.sv */
// shared constants, register index codes and stage structs for the bmp pixel stream blitter
// no dependencies; imported by every module of the block
package bpsb_pkg;

   localparam int SCREEN_WIDTH  = 800;
   localparam int SCREEN_HEIGHT = 480;
   localparam int MAX_IMAGE_DIM = 4096;

   localparam int DIM_W       = $clog2(MAX_IMAGE_DIM + 1);
   localparam int COUNT_W     = (MAX_IMAGE_DIM > 1) ? $clog2(MAX_IMAGE_DIM) : 1;
   localparam int DEST_W      = 13;
   localparam int SIZE_W      = 14;
   localparam int CSR_DATA_W  = 14;
   localparam int CSR_INDEX_W = 3;
   localparam int BYTE_W      = 8;
   localparam int COLOR_W     = 32;
   localparam int ADDR_W      = 19;
   localparam int COORD_W     = ((DIM_W > DEST_W) ? DIM_W : DEST_W) + 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEST_X       = 3'd0,
      CSR_DEST_Y       = 3'd1,
      CSR_IMAGE_WIDTH  = 3'd2,
      CSR_IMAGE_HEIGHT = 3'd3,
      CSR_DEPTH_IS_32  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [DEST_W-1:0] dest_x;
      logic signed [DEST_W-1:0] dest_y;
      logic                     width_neg;
      logic [DIM_W-1:0]         dw;
      logic                     height_neg;
      logic [DIM_W-1:0]         dh;
      logic                     depth_is_32;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic [COLOR_W-1:0]        color;
   } pixel_type;

endpackage

/* hw/rtl/bpsb_csr.sv */
// configuration registers; image sizes are kept as sign plus capped magnitude
// depends on bpsb_pkg
module bpsb_csr
   import bpsb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   function automatic logic [DIM_W-1:0] magnitude(logic signed [SIZE_W-1:0] v);
      logic signed [SIZE_W:0] ve;
      logic [SIZE_W:0]        a;
      ve = (SIZE_W + 1)'(v);
      a  = $unsigned(ve[SIZE_W] ? -ve : ve);
      if (int'(a) > MAX_IMAGE_DIM)
         return DIM_W'(MAX_IMAGE_DIM);
      return DIM_W'(a);
   endfunction

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEST_X: cfg_in.dest_x = $signed(csr_data[DEST_W-1:0]);
            CSR_DEST_Y: cfg_in.dest_y = $signed(csr_data[DEST_W-1:0]);
            CSR_IMAGE_WIDTH: begin
               cfg_in.width_neg = csr_data[SIZE_W-1];
               cfg_in.dw        = magnitude($signed(csr_data[SIZE_W-1:0]));
            end
            CSR_IMAGE_HEIGHT: begin
               cfg_in.height_neg = csr_data[SIZE_W-1];
               cfg_in.dh         = magnitude($signed(csr_data[SIZE_W-1:0]));
            end
            CSR_DEPTH_IS_32: cfg_in.depth_is_32 = csr_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_x      <= '0;
         cfg_ff.dest_y      <= '0;
         cfg_ff.width_neg   <= 1'b0;
         cfg_ff.dw          <= magnitude(SIZE_W'(800));
         cfg_ff.height_neg  <= 1'b0;
         cfg_ff.dh          <= magnitude(SIZE_W'(480));
         cfg_ff.depth_is_32 <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/bpsb_unpack.sv */
// byte gathering, row padding skip and column/row counting; holds one finished pixel
// depends on bpsb_pkg
module bpsb_unpack
   import bpsb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_pixel_byte,
   input  logic              out_free,
   output logic              pix_valid,
   output pixel_type         pix
);

   typedef enum logic [3:0] {
      PH_BLUE  = 4'b0001,
      PH_GREEN = 4'b0010,
      PH_RED   = 4'b0100,
      PH_ALPHA = 4'b1000
   } phase_type;

   localparam logic signed [COORD_W-1:0] COORD_ONE = COORD_W'(1);

   phase_type            phase_ff, phase_in;
   logic [23:0]          partial_ff, partial_in;
   logic [COUNT_W-1:0]   col_ff, col_in;
   logic [COUNT_W-1:0]   row_ff, row_in;
   logic [1:0]           pad_ff, pad_in;
   logic                 s1_valid_ff, s1_valid_in;
   pixel_type            s1_ff, s1_in;

   logic                      accept;
   logic                      active;
   logic                      complete;
   logic [COLOR_W-1:0]        color;
   logic [COUNT_W-1:0]        col_w;
   logic [COUNT_W-1:0]        row_w;
   logic [DIM_W-1:0]          col_next;
   logic [DIM_W-1:0]          row_next;
   logic signed [COORD_W-1:0] dx_e, dy_e, dw_e, dh_e, col_e, row_e;
   logic signed [COORD_W-1:0] sx, sy;

   assign req_stall = s1_valid_ff & ~out_free;
   assign accept    = req_valid & ~req_stall;
   assign active    = accept & (cfg.dw != '0) & (cfg.dh != '0);

   assign col_w    = (DIM_W'(col_ff) >= cfg.dw) ? '0 : col_ff;
   assign row_w    = (DIM_W'(row_ff) >= cfg.dh) ? '0 : row_ff;
   assign col_next = DIM_W'(col_w) + DIM_W'(1);
   assign row_next = DIM_W'(row_w) + DIM_W'(1);

   assign dx_e  = COORD_W'(cfg.dest_x);
   assign dy_e  = COORD_W'(cfg.dest_y);
   assign dw_e  = $signed(COORD_W'(cfg.dw));
   assign dh_e  = $signed(COORD_W'(cfg.dh));
   assign col_e = $signed(COORD_W'(col_w));
   assign row_e = $signed(COORD_W'(row_w));

   // mirrored columns for negative width, flipped rows for positive height
   assign sx = cfg.width_neg  ? (dw_e + dx_e - COORD_ONE - col_e) : (dx_e + col_e);
   assign sy = cfg.height_neg ? (dy_e + row_e) : (dy_e + dh_e - COORD_ONE - row_e);

   always_comb begin
      phase_in   = phase_ff;
      partial_in = partial_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      pad_in     = pad_ff;
      complete   = 1'b0;
      color      = '0;
      if (active) begin
         if (pad_ff != 2'd0) begin
            pad_in = pad_ff - 2'd1;
         end else begin
            unique case (phase_ff)
               PH_BLUE: begin
                  partial_in[7:0] = req_pixel_byte;
                  phase_in        = PH_GREEN;
               end
               PH_GREEN: begin
                  partial_in[15:8] = req_pixel_byte;
                  phase_in         = PH_RED;
               end
               PH_RED: begin
                  partial_in[23:16] = req_pixel_byte;
                  if (cfg.depth_is_32) begin
                     phase_in = PH_ALPHA;
                  end else begin
                     complete = 1'b1;
                     color    = {8'h00, req_pixel_byte, partial_ff[15:0]};
                  end
               end
               PH_ALPHA: begin
                  complete = 1'b1;
                  color    = {cfg.depth_is_32 ? req_pixel_byte : 8'h00, partial_ff};
               end
               default: phase_in = PH_BLUE;
            endcase
            if (complete) begin
               phase_in = PH_BLUE;
               if (col_next >= cfg.dw) begin
                  col_in = '0;
                  row_in = (row_next >= cfg.dh) ? '0 : COUNT_W'(row_next);
                  pad_in = cfg.depth_is_32 ? 2'd0 : 2'(cfg.dw);
               end else begin
                  col_in = COUNT_W'(col_next);
                  row_in = row_w;
               end
            end
         end
      end
   end

   assign s1_valid_in = complete | (s1_valid_ff & ~out_free);

   always_comb begin
      s1_in = s1_ff;
      if (complete) begin
         s1_in.sx    = sx;
         s1_in.sy    = sy;
         s1_in.color = color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_BLUE;
         partial_ff  <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         pad_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         partial_ff  <= partial_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         pad_ff      <= pad_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign pix_valid = s1_valid_ff;
   assign pix       = s1_ff;

endmodule

/* hw/rtl/bpsb_map.sv */
// screen clipping, framebuffer address and the result register
// depends on bpsb_pkg
module bpsb_map
   import bpsb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               pix_valid,
   input  pixel_type          pix,
   output logic               out_free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ADDR_W-1:0]  rsp_pixel_address,
   output logic [COLOR_W-1:0] rsp_pixel_color
);

   localparam logic signed [COORD_W-1:0] SCR_W = COORD_W'(SCREEN_WIDTH);
   localparam logic signed [COORD_W-1:0] SCR_H = COORD_W'(SCREEN_HEIGHT);

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [COLOR_W-1:0] color_ff, color_in;

   logic              load;
   logic              on_screen;
   logic [ADDR_W-1:0] row_base;
   logic [ADDR_W-1:0] addr;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign load      = pix_valid & out_free;
   assign on_screen = ~pix.sx[COORD_W-1] & (pix.sx < SCR_W)
                    & ~pix.sy[COORD_W-1] & (pix.sy < SCR_H);

   assign row_base = ADDR_W'(pix.sy) * ADDR_W'(SCREEN_WIDTH);
   assign addr     = ADDR_W'(pix.sx) + row_base;

   assign rsp_valid_in = load ? on_screen : (rsp_valid_ff & rsp_stall);
   assign addr_in      = load ? addr : addr_ff;
   assign color_in     = load ? pix.color : color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      color_ff <= color_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_pixel_color   = color_ff;

endmodule

/* hw/rtl/bmp_pixel_stream_blitter.sv */
// top level of the bmp pixel stream blitter
// depends on bpsb_pkg, bpsb_csr, bpsb_unpack and bpsb_map
//
// usage
//   req_ channel: one byte of a 24-bit or 32-bit bmp pixel array per transaction,
//   row padding included; a transaction completes when req_valid is high and
//   req_stall is low.
//   rsp_ channel: one transaction per on-screen pixel, carrying the framebuffer
//   word index and the argb colour; off-screen pixels give no transaction.
//   csr_ port: csr_write with csr_index and csr_data writes one register in the
//   cycle it is high; write only while the stream is idle.
//   throughput: one byte per cycle while req_stall is low.
//   result path: the byte that completes a pixel is registered first in the pixel
//   stage, then in the result register.
//   reset: registers return to an 800x480 24-bit image at the origin, and
//   byte phase, counters and padding are cleared.
//   stall: a stalled result holds; one more finished pixel waits in the pixel
//   stage, after which req_stall rises until rsp_stall drops.
module bmp_pixel_stream_blitter
   import bpsb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_pixel_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ADDR_W-1:0]      rsp_pixel_address,
   output logic [COLOR_W-1:0]     rsp_pixel_color
);

   cfg_type   cfg;
   logic      pix_valid;
   pixel_type pix;
   logic      out_free;

   bpsb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bpsb_unpack u_unpack (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_byte (req_pixel_byte),
      .out_free       (out_free),
      .pix_valid      (pix_valid),
      .pix            (pix)
   );

   bpsb_map u_map (
      .clock             (clock),
      .reset             (reset),
      .pix_valid         (pix_valid),
      .pix               (pix),
      .out_free          (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color)
   );

endmodule

/* hw/rtl/bpsb_checker.sv */
// port-level checks for the bmp pixel stream blitter, bound to the top level
// depends on bpsb_pkg and bmp_pixel_stream_blitter
module bpsb_checker
   import bpsb_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [ADDR_W-1:0]      rsp_pixel_address,
   input logic [COLOR_W-1:0]     rsp_pixel_color
);

   localparam int FB_WORDS = SCREEN_WIDTH * SCREEN_HEIGHT;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_address)
                                 && $stable(rsp_pixel_color))
      else $error("stalled result changed");

   // back-pressure on req_ only comes from a stalled result
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled result");

   // a fresh result follows a byte transaction that passed the pixel stage and the result register
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a completing byte");

   // addresses stay inside the framebuffer
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_pixel_address) < FB_WORDS)
      else $error("pixel address beyond the framebuffer");

endmodule

bind bmp_pixel_stream_blitter bpsb_checker u_checker (.*);
